>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define WBPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wbps_pkg.sv
// Package for the wildcard byte pattern scanner: sizes, opcodes, request and result types
// and the hex digit decoder. No dependencies.
package wbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int OFFSET_BITS = 32;

  localparam logic [7:0] WILDCARD_CHAR = 8'h3F;  // '?'
  localparam logic [7:0] SPACE_CHAR    = 8'h20;  // ' '

  typedef enum logic [1:0] {
    OP_PAT_CHAR  = 2'd0,
    OP_DATA      = 2'd1,
    OP_RESTART   = 2'd2,
    OP_CLEAR_PAT = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  value;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_dig_t;

  function automatic hex_dig_t hex_decode(input logic [7:0] c);
    hex_dig_t d;
    d = '{ok: 1'b0, nib: 4'd0};
    if (c >= 8'h30 && c <= 8'h39) begin
      d = '{ok: 1'b1, nib: 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = '{ok: 1'b1, nib: 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = '{ok: 1'b1, nib: 4'(c - 8'h57)};
    end
    return d;
  endfunction

endpackage

>>> rtl/wildcard_byte_pattern_scanner_top.sv
// Wildcard byte pattern scanner, top level.
// Depends on wbps_pkg.
//
//   channel | dir | payload             | handshake
//   in_     | in  | wbps_pkg::in_item_t  | in_valid / in_stall
//   out_    | out | wbps_pkg::out_item_t | out_valid / out_stall
//
// One request per cycle, every opcode, while in_stall is low; a request waits in
// the input register until the result register can take it, and any result is
// registered there (input register, then result register). The window compare
// runs over all MAX_PATTERN lanes combinationally. Reset clears pattern length,
// scan counters and both valid flags; no clearing pass. in_stall rises only while
// the input register holds a request that cannot move into a stalled result.
module wildcard_byte_pattern_scanner_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wbps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wbps_pkg::out_item_t out_data
);

  localparam int NP = wbps_pkg::MAX_PATTERN;
  localparam int LW = wbps_pkg::LEN_W;
  localparam int OW = wbps_pkg::OFFSET_BITS;

  // input register
  logic               st_valid_r, st_valid_nxt;
  wbps_pkg::in_item_t st_item_r;

  // pattern, newest element at index 0 so lane k lines up with window age k
  logic [7:0]    pat_r    [NP];
  logic [7:0]    pat_nxt  [NP];
  logic [NP-1:0] wild_r, wild_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [3:0]    prev_nib_r, prev_nib_nxt;
  logic          prev_hex_r, prev_hex_nxt;

  // scan state, newest byte at index 0
  logic [7:0]    win_r    [NP];
  logic [7:0]    win_nxt  [NP];
  logic [LW-1:0] seen_r, seen_nxt;
  logic [OW-1:0] pos_r, pos_nxt;
  logic          done_r, done_nxt;

  logic                out_valid_r, out_valid_nxt;
  wbps_pkg::out_item_t out_data_r, out_data_nxt;

  logic                fire;
  logic                res_valid;
  wbps_pkg::out_item_t res;
  wbps_pkg::hex_dig_t  hd;
  logic [NP-1:0]       lane_ok;
  logic [LW-1:0]       seen_inc;
  logic [OW-1:0]       start;
  logic                add_el;
  logic [7:0]          el_byte;
  logic                el_wild;

  assign fire     = st_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = st_valid_r && !fire;
  assign st_valid_nxt = (in_valid && !in_stall) ? 1'b1 : (fire ? 1'b0 : st_valid_r);

  assign hd       = wbps_pkg::hex_decode(st_item_r.value);
  assign seen_inc = (seen_r < len_r) ? seen_r + LW'(1) : seen_r;
  assign start    = pos_r - OW'(len_r) + OW'(1);

  // window as it stands once the new byte is shifted in
  always_comb begin
    win_nxt[0] = st_item_r.value;
    for (int k = 1; k < NP; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      lane_ok[k] = (LW'(k) >= len_r) || wild_r[k] || (win_nxt[k] == pat_r[k]);
    end
  end

  // pattern element from a text character: hex pair or wildcard
  always_comb begin
    add_el  = 1'b0;
    el_byte = 8'd0;
    el_wild = 1'b0;
    if (prev_hex_r && hd.ok) begin
      add_el  = 1'b1;
      el_byte = {prev_nib_r, hd.nib};
    end else if (st_item_r.value == wbps_pkg::WILDCARD_CHAR) begin
      add_el  = 1'b1;
      el_wild = 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      pat_nxt[k] = pat_r[k];
    end
    wild_nxt     = wild_r;
    len_nxt      = len_r;
    prev_nib_nxt = prev_nib_r;
    prev_hex_nxt = prev_hex_r;
    seen_nxt     = seen_r;
    pos_nxt      = pos_r;
    done_nxt     = done_r;
    res_valid    = 1'b0;
    res          = '0;
    if (fire) begin
      case (st_item_r.opcode)
        wbps_pkg::OP_PAT_CHAR: begin
          if (add_el && (len_r < LW'(NP))) begin
            pat_nxt[0] = el_byte;
            for (int k = 1; k < NP; k++) begin
              pat_nxt[k] = pat_r[k-1];
            end
            wild_nxt = {wild_r[NP-2:0], el_wild};
            len_nxt  = len_r + LW'(1);
          end
          prev_nib_nxt = hd.nib;
          prev_hex_nxt = hd.ok && (st_item_r.value != wbps_pkg::SPACE_CHAR);
        end
        wbps_pkg::OP_DATA: begin
          if (!done_r) begin
            seen_nxt = seen_inc;
            pos_nxt  = pos_r + OW'(1);
            if (len_r == '0) begin
              res_valid = 1'b1;
              res       = '{found: 1'b1, offset: 32'd0};
              done_nxt  = 1'b1;
            end else if ((seen_inc >= len_r) && (&lane_ok)) begin
              res_valid = 1'b1;
              res       = '{found: 1'b1, offset: 32'(start)};
              done_nxt  = 1'b1;
            end else if (st_item_r.last) begin
              res_valid = 1'b1;
              res       = '{found: 1'b0, offset: 32'd0};
            end
          end
          if (st_item_r.last) begin
            seen_nxt = '0;
            pos_nxt  = '0;
            done_nxt = 1'b0;
          end
        end
        wbps_pkg::OP_RESTART: begin
          seen_nxt = '0;
          pos_nxt  = '0;
          done_nxt = 1'b0;
        end
        wbps_pkg::OP_CLEAR_PAT: begin
          len_nxt      = '0;
          prev_hex_nxt = 1'b0;
          seen_nxt     = '0;
          pos_nxt      = '0;
          done_nxt     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = res_valid ? 1'b1 : (out_valid_r && out_stall);
  assign out_data_nxt  = res_valid ? res : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      len_r       <= '0;
      prev_hex_r  <= 1'b0;
      seen_r      <= '0;
      pos_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_valid_r  <= st_valid_nxt;
      len_r       <= len_nxt;
      prev_hex_r  <= prev_hex_nxt;
      seen_r      <= seen_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset; window lanes below seen_r are always from this region
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      st_item_r <= in_data;
    end
    if (fire && (st_item_r.opcode == wbps_pkg::OP_DATA) && !done_r) begin
      for (int k = 0; k < NP; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
    for (int k = 0; k < NP; k++) begin
      pat_r[k] <= pat_nxt[k];
    end
    wild_r     <= wild_nxt;
    prev_nib_r <= prev_nib_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/wbps_checker.sv
// Port-level checker for the wildcard byte pattern scanner, bound to the top.
// Depends on wbps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input wbps_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input wbps_pkg::out_item_t out_data
);

  `WBPS_ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid, "out_valid after reset")

  `WBPS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  `WBPS_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_data.found |-> out_data.offset == 32'd0, "not-found result with nonzero offset")

  // a fresh result comes from a data request taken before it
  `WBPS_ASSERT(a_rise_src, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.opcode == wbps_pkg::OP_DATA, 2), "result without data request")

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> dv/tb_wildcard_byte_pattern_scanner_top.sv
// Self-checking testbench for wildcard_byte_pattern_scanner_top: pattern loads, scans,
// backpressure and random signature/region traffic checked against a behavioral scan model.
// Depends on wbps_pkg and the scanner RTL.
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner_top;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REQUEST_TARGET = 1050;
  localparam int REPORT_LIMIT   = 10;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  wbps_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  wbps_pkg::out_item_t out_data;

  // scan model state
  logic [7:0]  sig_byte [wbps_pkg::MAX_PATTERN];
  bit          sig_wild [wbps_pkg::MAX_PATTERN];
  int unsigned sig_len = 0;
  logic [7:0]  prior_char = 8'h00;
  bit          prior_hex = 1'b0;
  logic [7:0]  recent_bytes [wbps_pkg::MAX_PATTERN];
  int unsigned window_fill = 0;
  logic [31:0] region_pos = '0;
  bit          region_done = 1'b0;

  wbps_pkg::out_item_t pending_results [$];
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned matches_found = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned hold_len = 0;

  wildcard_byte_pattern_scanner_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;       // 0-9
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;  // A-F
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;  // a-f
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic void append_element(logic [7:0] b, bit wild);
    if (sig_len < wbps_pkg::MAX_PATTERN) begin
      sig_byte[sig_len] = b;
      sig_wild[sig_len] = wild;
      sig_len++;
    end
  endfunction

  function automatic void rearm_region();
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
    window_fill = 0;
    region_pos  = '0;
    region_done = 1'b0;
  endfunction

  function automatic void queue_expected(bit found, logic [31:0] offset);
    wbps_pkg::out_item_t item;
    item.found  = found;
    item.offset = offset;
    pending_results.insert(pending_results.size(), item);
  endfunction

  // Advances the scan model by one request and queues the result it causes, if any.
  function automatic void predict_scan(wbps_pkg::in_item_t r);
    int h;
    bit hit;
    logic [31:0] start;
    case (r.opcode)
      wbps_pkg::OP_PAT_CHAR: begin
        h = nibble_of(r.value);
        if (prior_hex && h >= 0) append_element(8'(nibble_of(prior_char) * 16 + h), 1'b0);
        if (r.value == wbps_pkg::WILDCARD_CHAR) append_element(8'h00, 1'b1);
        prior_char = r.value;
        prior_hex  = (r.value != wbps_pkg::SPACE_CHAR) && (h >= 0);
      end
      wbps_pkg::OP_RESTART: rearm_region();
      wbps_pkg::OP_CLEAR_PAT: begin
        sig_len    = 0;
        prior_char = 8'h00;
        prior_hex  = 1'b0;
        rearm_region();
      end
      default: begin
        if (region_done) begin
          if (r.last) rearm_region();
          return;
        end
        for (int i = wbps_pkg::MAX_PATTERN - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
        recent_bytes[0] = r.value;
        if (window_fill < sig_len) window_fill++;
        hit   = 1'b0;
        start = '0;
        if (sig_len == 0) begin
          hit = 1'b1;
        end else if (window_fill >= sig_len) begin
          hit = 1'b1;
          for (int i = 0; i < sig_len; i++) begin
            if (!sig_wild[i] && recent_bytes[sig_len - 1 - i] != sig_byte[i]) hit = 1'b0;
          end
          if (hit) start = region_pos - 32'(sig_len - 1);
        end
        region_pos++;
        if (hit) begin
          queue_expected(1'b1, start);
          matches_found++;
          region_done = 1'b1;
          if (r.last) rearm_region();
        end else if (r.last) begin
          queue_expected(1'b0, 32'd0);
          rearm_region();
        end
      end
    endcase
  endfunction

  function automatic void check_result(wbps_pkg::out_item_t got);
    wbps_pkg::out_item_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("cycle %0d: unexpected result found=%0b offset=%0d",
                 cycle_count, got.found, got.offset);
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found || got.offset !== want.offset) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("cycle %0d: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                 cycle_count, want.found, want.offset, got.found, got.offset);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stall driver; a hold request overrides the random pattern
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one request and returns at the edge where it is taken.
  task automatic send_request(wbps_pkg::opcode_t op, logic [7:0] v, logic l);
    int unsigned gap;
    wbps_pkg::in_item_t r;
    r = '{opcode: op, value: v, last: l};
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
    predict_scan(r);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(wbps_pkg::OP_PAT_CHAR, s[i], 1'b0);
  endtask

  task automatic test_directed_cases();
    // empty pattern: first byte matches at 0, rest of region ignored
    send_request(wbps_pkg::OP_CLEAR_PAT, 8'hFF, 1'b1);
    send_request(wbps_pkg::OP_DATA, 8'h00, 1'b0);
    send_request(wbps_pkg::OP_DATA, 8'hFF, 1'b1);
    // mixed case, space, wildcard
    send_text("aB ?c0");
    send_request(wbps_pkg::OP_DATA, 8'h00, 1'b0);
    send_request(wbps_pkg::OP_DATA, 8'hAB, 1'b0);
    send_request(wbps_pkg::OP_DATA, 8'h55, 1'b0);
    send_request(wbps_pkg::OP_DATA, 8'hC0, 1'b0);
    send_request(wbps_pkg::OP_DATA, 8'h12, 1'b0);
    send_request(wbps_pkg::OP_DATA, 8'hC0, 1'b1);
    // last on a non-data op is ignored; region too short ends not found
    send_request(wbps_pkg::OP_RESTART, 8'h00, 1'b1);
    send_request(wbps_pkg::OP_DATA, 8'h11, 1'b1);
    // non-hex chars break a pair, then overlapping pairs
    send_request(wbps_pkg::OP_CLEAR_PAT, 8'h00, 1'b0);
    send_text("1");
    send_request(wbps_pkg::OP_PAT_CHAR, 8'h00, 1'b0);
    send_text("2G");
    send_request(wbps_pkg::OP_PAT_CHAR, 8'hFF, 1'b1);
    send_text("ABC");
    send_request(wbps_pkg::OP_DATA, 8'hAB, 1'b0);
    // pattern grows mid-scan
    send_text("?");
    send_request(wbps_pkg::OP_DATA, 8'hBC, 1'b0);
    send_request(wbps_pkg::OP_DATA, 8'h00, 1'b1);
  endtask

  // more elements than the store holds; the extra ones are dropped
  task automatic test_pattern_overflow();
    logic [7:0] region [40];
    foreach (region[i]) region[i] = 8'($urandom);
    send_request(wbps_pkg::OP_CLEAR_PAT, 8'h3C, 1'b0);
    for (int k = 0; k < 36; k++) begin
      if (k % 7 == 3) begin
        send_request(wbps_pkg::OP_PAT_CHAR, wbps_pkg::WILDCARD_CHAR, 1'b0);
      end else begin
        send_request(wbps_pkg::OP_PAT_CHAR, hex_char(region[4+k][7:4], k[0]), 1'b0);
        send_request(wbps_pkg::OP_PAT_CHAR, hex_char(region[4+k][3:0], k[1]), 1'b1);
      end
      send_request(wbps_pkg::OP_PAT_CHAR, wbps_pkg::SPACE_CHAR, 1'b0);
    end
    send_text("Ff");
    for (int k = 0; k < 40; k++) send_request(wbps_pkg::OP_DATA, region[k], k == 39);
  endtask

  // receiver holds off while requests keep coming, so the input side backs up
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    hold_len = 250;
    send_request(wbps_pkg::OP_CLEAR_PAT, 8'h00, 1'b0);
    for (int k = 0; k < 40; k++) send_request(wbps_pkg::OP_DATA, 8'($urandom), 1'b1);
    gaps_on = 1'b1;
  endtask

  // a signature load taken from the region's own bytes, or a restart, then the region
  task automatic run_scan_sequence();
    logic [7:0] region [$];
    logic [7:0] b;
    int unsigned rlen, plen, at;
    bit narrow;
    region = {};
    rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
    narrow = $urandom_range(0, 1);
    for (int k = 0; k < rlen; k++)
      region.insert(region.size(), narrow ? 8'($urandom_range(0, 3)) : 8'($urandom));
    gaps_on  = ($urandom_range(0, 3) != 0);
    stall_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 4) == 0) begin
      send_request(wbps_pkg::OP_RESTART, 8'($urandom), 1'($urandom));
    end else begin
      send_request(wbps_pkg::OP_CLEAR_PAT, 8'($urandom), 1'($urandom));
      plen = $urandom_range(0, (rlen < 12) ? rlen : 12);
      at = $urandom_range(0, rlen - plen);
      for (int k = 0; k < plen; k++) begin
        b = region[at + k];
        if ($urandom_range(0, 9) == 0) b = b ^ (8'd1 << $urandom_range(0, 7));
        if ($urandom_range(0, 4) == 0) begin
          send_request(wbps_pkg::OP_PAT_CHAR, wbps_pkg::WILDCARD_CHAR, 1'($urandom));
        end else begin
          send_request(wbps_pkg::OP_PAT_CHAR, hex_char(b[7:4], 1'($urandom)), 1'($urandom));
          send_request(wbps_pkg::OP_PAT_CHAR, hex_char(b[3:0], 1'($urandom)), 1'($urandom));
        end
        // usually a space; sometimes junk, sometimes nothing so pairs overlap
        case ($urandom_range(0, 9))
          0: begin
          end
          1: send_request(wbps_pkg::OP_PAT_CHAR, 8'($urandom), 1'($urandom));
          default: send_request(wbps_pkg::OP_PAT_CHAR, wbps_pkg::SPACE_CHAR, 1'($urandom));
        endcase
      end
    end
    for (int k = 0; k < rlen; k++) begin
      if ($urandom_range(0, 24) == 0)
        send_request(wbps_pkg::opcode_t'(2'($urandom_range(0, 3))), 8'($urandom),
                     1'($urandom));
      send_request(wbps_pkg::OP_DATA, region[k], k == rlen - 1);
    end
  endtask

  task automatic test_random_scans();
    while (requests_sent < REQUEST_TARGET)
      run_scan_sequence();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_pattern_overflow();
    test_output_backpressure();
    test_random_scans();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Scanned %0d requests (signature loads, regions, restarts, overflow, hold-off);",
             requests_sent);
    $display("%0d results checked, %0d of them matches, %0d mismatches.",
             results_checked, matches_found, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
